// File: design/escaped_frame_receiver_assert.svh
// Assertion macros shared by the escaped frame receiver RTL.
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/efr_pkg.sv
// Package with types and constants of the escaped frame receiver.
package efr_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 4;

  localparam logic [7:0] ESC_BYTE   = 8'h5C;
  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] END_BYTE   = 8'h0A;
  localparam logic [7:0] HEADER_RST = 8'h01;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } res_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

endpackage

// File: design/efr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = efr_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/efr_fifo.sv
// Small flip-flop queue used for the command and result queues.
module efr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = efr_pkg::CMD_Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/efr_front.sv
// Front end: accepts raw bytes, tracks escapes and classifies each byte.
module efr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_rx_byte,
  input  logic          cmd_full,
  output logic          cmd_push,
  output efr_pkg::cmd_t cmd
);

  logic esc_r, esc_nxt;
  logic accept;

  assign accept = in_push && !cmd_full;

  always_comb begin
    esc_nxt  = esc_r;
    cmd_push = 1'b0;
    cmd.op   = efr_pkg::CMD_DATA;
    cmd.data = in_rx_byte;
    if (accept) begin
      // Start and end bytes are framing codes only without a pending escape; after one they are data.
      priority if (!esc_r && in_rx_byte == efr_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else if (!esc_r && in_rx_byte == efr_pkg::START_BYTE) begin
        cmd_push = 1'b1;
        cmd.op   = efr_pkg::CMD_START;
      end else if (!esc_r && in_rx_byte == efr_pkg::END_BYTE) begin
        cmd_push = 1'b1;
        cmd.op   = efr_pkg::CMD_END;
      end else begin
        cmd_push = 1'b1;
        esc_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule

// File: design/efr_back.sv
// Back end: owns the frame store, appends data and replays finished frames.
module efr_back #(
  parameter int STORE_DEPTH = efr_pkg::STORE_DEPTH,
  parameter int OUT_Q_DEPTH = efr_pkg::OUT_Q_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [7:0]                       header,
  input  logic                             cmd_valid,
  input  efr_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  input  logic [$clog2(OUT_Q_DEPTH+1)-1:0] oq_count,
  output logic                             oq_push,
  output efr_pkg::res_t                    oq_item
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int FW  = $clog2(STORE_DEPTH + 1);
  localparam int OCW = $clog2(OUT_Q_DEPTH + 1);

  efr_pkg::bk_state_t state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [7:0]         hdr_r, hdr_nxt;
  logic               infl_r, infl_nxt;
  logic               infl_last_r, infl_last_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  logic [OCW:0]       occupancy;
  logic               credit_ok;
  logic               match;
  logic               go_emit;
  logic               issue;
  logic               issue_last;

  // Slots already taken in the result queue, counting a read still in flight.
  assign occupancy = {1'b0, oq_count} + (OCW + 1)'(infl_r);
  assign credit_ok = occupancy < (OCW + 1)'(OUT_Q_DEPTH);
  assign match     = (fill_r != '0) && (hdr_r == header);

  efr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output and datapath control.
  always_comb begin
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = (fill_r >= FW'(STORE_DEPTH)) ? '0 : fill_r[AW-1:0];
    ram_raddr     = rd_idx_r[AW-1:0];
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    hdr_nxt       = hdr_r;
    go_emit       = 1'b0;
    issue         = 1'b0;
    issue_last    = (rd_idx_r == fill_r - FW'(1));
    infl_last_nxt = infl_last_r;
    oq_push       = 1'b0;
    oq_item.payload_byte  = ram_rdata;
    oq_item.last_of_frame = infl_last_r;
    oq_item.empty_frame   = 1'b0;

    unique case (state_r)
      efr_pkg::BK_IDLE: begin
        if (cmd_valid && !infl_r) begin
          unique case (cmd.op)
            efr_pkg::CMD_DATA: begin
              cmd_pop  = 1'b1;
              ram_we   = 1'b1;
              fill_nxt = (fill_r >= FW'(STORE_DEPTH)) ? FW'(1) : fill_r + FW'(1);
              if (ram_waddr == '0) begin
                hdr_nxt = cmd.data;
              end
            end
            efr_pkg::CMD_START: begin
              cmd_pop  = 1'b1;
              fill_nxt = '0;
            end
            efr_pkg::CMD_END: begin
              if (!match) begin
                cmd_pop = 1'b1;
              end else if (fill_r == FW'(1)) begin
                // Header-only frame gives a single empty marker.
                if (credit_ok) begin
                  cmd_pop               = 1'b1;
                  oq_push               = 1'b1;
                  oq_item.payload_byte  = '0;
                  oq_item.last_of_frame = 1'b1;
                  oq_item.empty_frame   = 1'b1;
                end
              end else begin
                cmd_pop    = 1'b1;
                go_emit    = 1'b1;
                rd_idx_nxt = FW'(1);
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      efr_pkg::BK_EMIT: begin
        if (credit_ok) begin
          issue         = 1'b1;
          infl_last_nxt = issue_last;
          rd_idx_nxt    = rd_idx_r + FW'(1);
        end
      end
      default: begin
      end
    endcase

    // Read data returns in the cycle after the address was issued.
    if (infl_r) begin
      oq_push = 1'b1;
    end
    infl_nxt = issue;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efr_pkg::BK_IDLE: begin
        if (go_emit) begin
          state_nxt = efr_pkg::BK_EMIT;
        end
      end
      efr_pkg::BK_EMIT: begin
        if (issue && issue_last) begin
          state_nxt = efr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = efr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efr_pkg::BK_IDLE;
      fill_r  <= '0;
      infl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      infl_r  <= infl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    hdr_r       <= hdr_nxt;
    infl_last_r <= infl_last_nxt;
  end

endmodule

// File: design/escaped_frame_receiver.sv
// A data byte enters the command queue as it is accepted and is stored when the back end pops it.
// A matching end byte's first result goes via the emit state, a store read and the result queue.
// Throughput: one item per cycle; a replay gives one result per cycle while the result queue has
// room and stalls the input once the two-entry command queue fills. A header-only frame gives its
// marker. Reset is synchronous: escape flag, fill count, queues clear and the header returns to
// 0x01. The frame store keeps no reset value and needs no clearing pass.
`include "escaped_frame_receiver_assert.svh"

module escaped_frame_receiver #(
  parameter int STORE_DEPTH = efr_pkg::STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_frame,
  output logic       out_empty_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_accepted_header
);

  localparam int CW  = $bits(efr_pkg::cmd_t);
  localparam int RW  = $bits(efr_pkg::res_t);
  localparam int CCW = $clog2(efr_pkg::CMD_Q_DEPTH + 1);
  localparam int OCW = $clog2(efr_pkg::OUT_Q_DEPTH + 1);
  localparam logic [CCW-1:0] CMD_Q_LIM = CCW'(efr_pkg::CMD_Q_DEPTH);

  logic [7:0]    header_r;

  logic          cmd_push;
  efr_pkg::cmd_t cmd_in;
  efr_pkg::cmd_t cmd_out;
  logic [CW-1:0] cmd_rdata;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic [CCW-1:0] cmd_count;

  logic          oq_push;
  efr_pkg::res_t oq_item;
  efr_pkg::res_t oq_head;
  logic [RW-1:0] oq_rdata;
  logic          oq_full;
  logic [OCW-1:0] oq_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= efr_pkg::HEADER_RST;
    end else if (cfg_valid && cfg_ready) begin
      header_r <= cfg_accepted_header;
    end
  end

  efr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  assign in_full = cmd_full;

  efr_fifo #(
    .WIDTH (CW),
    .DEPTH (efr_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign cmd_out = efr_pkg::cmd_t'(cmd_rdata);

  efr_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .OUT_Q_DEPTH (efr_pkg::OUT_Q_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .header    (header_r),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  efr_fifo #(
    .WIDTH (RW),
    .DEPTH (efr_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_item),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .full  (oq_full),
    .empty (out_empty),
    .count (oq_count)
  );

  assign oq_head           = efr_pkg::res_t'(oq_rdata);
  assign out_payload_byte  = oq_head.payload_byte;
  assign out_last_of_frame = oq_head.last_of_frame;
  assign out_empty_frame   = oq_head.empty_frame;

  // The back end must reserve a result slot before every push.
  `EFR_ASSERT_NOW(a_oq_no_overflow, oq_push, !oq_full, "result queue overflow")
  // The front end must never push into a full command queue.
  `EFR_ASSERT_NOW(a_cmd_no_overflow, cmd_push, cmd_count != CMD_Q_LIM, "command queue overflow")
  // An empty marker always closes its frame.
  `EFR_ASSERT_NOW(a_marker_is_last, (!out_empty && out_empty_frame), out_last_of_frame, "empty marker without last flag")
  // A pushed result shows up at the result ports no later than the next cycle.
  `EFR_ASSERT_NEXT(a_push_visible, oq_push, !out_empty, "pushed result not visible")

endmodule

// File: tb/sv/testbench.sv
// Testbench for the escaped frame receiver: directed and random byte streams against a model.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CFG_SETTLE     = 16;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_full;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_last_of_frame;
  logic       out_empty_frame;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_accepted_header = 8'h00;

  // Frame model state.
  logic [7:0]    frame_model [efr_pkg::STORE_DEPTH];
  logic [6:0]    fill_model = '0;
  logic          esc_model = 1'b0;
  logic [7:0]    header_model = efr_pkg::HEADER_RST;
  efr_pkg::res_t frame_results_due [$];

  int   errors = 0;
  int   quiet_cycles = 0;
  int   bytes_sent = 0;
  int   recv_hold = 0;
  int   stall_left = 0;
  int   pop_roll;
  bit   send_gaps_on = 1'b1;
  bit   recv_gaps_on = 1'b1;
  efr_pkg::res_t want_item;

  escaped_frame_receiver DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_rx_byte          (in_rx_byte),
    .in_full             (in_full),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_empty_frame     (out_empty_frame),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_accepted_header (cfg_accepted_header)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one received byte to the model and queues the payload it releases.
  task automatic deframe_byte(input logic [7:0] b);
    efr_pkg::res_t item;
    int            i;
    if (!esc_model && b == efr_pkg::START_BYTE) begin
      fill_model = '0;
    end else if (!esc_model && b == efr_pkg::END_BYTE) begin
      if (fill_model != 0 && frame_model[0] == header_model) begin
        if (fill_model == 1) begin
          item.payload_byte  = 8'h00;
          item.last_of_frame = 1'b1;
          item.empty_frame   = 1'b1;
          frame_results_due.push_back(item);
        end else begin
          for (i = 1; i < fill_model; i++) begin
            item.payload_byte  = frame_model[i];
            item.last_of_frame = (i == fill_model - 1);
            item.empty_frame   = 1'b0;
            frame_results_due.push_back(item);
          end
        end
      end
    end else if (!esc_model && b == efr_pkg::ESC_BYTE) begin
      esc_model = 1'b1;
    end else begin
      if (fill_model >= efr_pkg::STORE_DEPTH) fill_model = '0;
      frame_model[fill_model[5:0]] = b;
      fill_model = fill_model + 7'd1;
      esc_model = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int roll;
    if (!send_gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Payload byte with the framing codes drawn more often than chance would give.
  function automatic logic [7:0] payload_pick();
    case ($urandom_range(0, 9))
      0: return efr_pkg::START_BYTE;
      1: return efr_pkg::END_BYTE;
      2: return efr_pkg::ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] line_noise();
    case ($urandom_range(0, 7))
      0: return efr_pkg::START_BYTE;
      1: return efr_pkg::END_BYTE;
      2: return efr_pkg::ESC_BYTE;
      3: return header_model;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one item and returns at the edge where it is taken; push stays high after.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic send_literal(input logic [7:0] b);
    if (b == efr_pkg::START_BYTE || b == efr_pkg::END_BYTE || b == efr_pkg::ESC_BYTE) begin
      send_byte(efr_pkg::ESC_BYTE);
    end
    send_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input int payload_len, input int end_count);
    send_byte(efr_pkg::START_BYTE);
    send_literal(hdr);
    repeat (payload_len) send_literal(payload_pick());
    repeat (end_count) send_byte(efr_pkg::END_BYTE);
  endtask

  task automatic wait_drained();
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  // The header may only change once the block has nothing in flight.
  task automatic write_header(input logic [7:0] h);
    idle_input();
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_accepted_header <= h;
    do @(posedge clk); while (!cfg_ready);
    header_model = h;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_bytes();
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::START_BYTE);
    send_byte(efr_pkg::HEADER_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::START_BYTE);
    send_byte(efr_pkg::HEADER_RST);
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::START_BYTE);
    send_byte(efr_pkg::HEADER_RST + 8'd1);
    send_byte(8'h33);
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::START_BYTE);
    send_byte(efr_pkg::HEADER_RST);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::START_BYTE);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::END_BYTE);
    idle_input();
  endtask

  task automatic test_header_extremes();
    logic [7:0] hdrs [5];
    hdrs = '{8'h00, 8'hFF, efr_pkg::END_BYTE, efr_pkg::ESC_BYTE, efr_pkg::START_BYTE};
    foreach (hdrs[k]) begin
      write_header(hdrs[k]);
      send_frame(hdrs[k], $urandom_range(0, 4), 1);
      send_frame(hdrs[k] ^ 8'h80, 2, 1);
    end
    idle_input();
  endtask

  // Fills the store exactly, then pushes one more byte to force the wrap to entry 0.
  task automatic test_full_store();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    write_header(efr_pkg::HEADER_RST);
    send_frame(header_model, efr_pkg::STORE_DEPTH - 1, 1);
    send_literal(header_model);
    send_byte(efr_pkg::END_BYTE);
    send_literal(payload_pick());
    send_byte(efr_pkg::END_BYTE);
    idle_input();
  endtask

  // The receiver holds off while the sender keeps offering bytes after the frame ends,
  // so both queues fill and the input stalls.
  task automatic test_output_backpressure();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    send_byte(efr_pkg::START_BYTE);
    recv_hold = HOLD_CYCLES;
    send_literal(header_model);
    repeat (12) send_literal(payload_pick());
    send_byte(efr_pkg::END_BYTE);
    send_byte(efr_pkg::END_BYTE);
    repeat (8) send_literal(payload_pick());
    idle_input();
  endtask

  task automatic test_sender_pause();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    send_frame(header_model, 10, 1);
    idle_input();
    wait_drained();
    send_frame(header_model, 5, 2);
    idle_input();
  endtask

  task automatic test_random_stream();
    int         start_count;
    int         len;
    logic [7:0] hdr;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        send_gaps_on = ($urandom_range(0, 3) != 0);
        recv_gaps_on = ($urandom_range(0, 3) != 0);
      end
      hdr = ($urandom_range(0, 4) != 0) ? header_model : 8'($urandom_range(0, 255));
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      case ($urandom_range(0, 11))
        7: repeat ($urandom_range(1, 6)) send_byte(line_noise());
        8: send_frame(hdr, len, 0);
        9: begin
          // A dangling escape turns the following framing code into data.
          send_byte(efr_pkg::ESC_BYTE);
          send_byte(($urandom_range(0, 1) != 0) ? efr_pkg::START_BYTE : efr_pkg::END_BYTE);
        end
        10: repeat ($urandom_range(1, 2)) send_byte(efr_pkg::END_BYTE);
        11: begin
          case ($urandom_range(0, 3))
            0: write_header(8'h00);
            1: write_header(8'hFF);
            2: write_header(efr_pkg::HEADER_RST);
            default: write_header(8'($urandom_range(0, 255)));
          endcase
        end
        default: send_frame(hdr, len, ($urandom_range(0, 7) == 0) ? 2 : 1);
      endcase
    end
    idle_input();
  endtask

  // Result side: paces pop with random stalls and honors an explicit hold.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_pop <= 1'b0;
    end else if (!recv_gaps_on) begin
      out_pop <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      pop_roll = $urandom_range(0, 99);
      if (pop_roll < 20) stall_left = $urandom_range(1, 3);
      else if (pop_roll < 23) stall_left = $urandom_range(15, 40);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (frame_results_due.size() == 0) begin
        errors++;
        $error("unexpected result item: payload_byte %02h last_of_frame %0b empty_frame %0b",
               out_payload_byte, out_last_of_frame, out_empty_frame);
      end else begin
        want_item = frame_results_due.pop_front();
        if (out_payload_byte !== want_item.payload_byte) begin
          errors++;
          $error("payload_byte: expected %02h, actual %02h",
                 want_item.payload_byte, out_payload_byte);
        end
        if (out_last_of_frame !== want_item.last_of_frame) begin
          errors++;
          $error("last_of_frame: expected %0b, actual %0b",
                 want_item.last_of_frame, out_last_of_frame);
        end
        if (out_empty_frame !== want_item.empty_frame) begin
          errors++;
          $error("empty_frame: expected %0b, actual %0b",
                 want_item.empty_frame, out_empty_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_bytes();
    test_header_extremes();
    test_full_store();
    test_output_backpressure();
    test_sender_pause();
    test_random_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && frame_results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
